// ----- sv/pct_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel color transform package
// Shared widths, codes, coefficient tables and payload types for the
// pixel color transform pipeline.
// ----------------------------------------------------------------------------
package pct_pkg;

   // Fixed-point precision of the color coefficients.
   localparam int COEF_FRAC_BITS = 16;

   localparam int CHAN_W = 8;
   localparam int COEF_W = COEF_FRAC_BITS;
   localparam int PROD_W = CHAN_W + COEF_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int INT_W  = SUM_W - COEF_FRAC_BITS;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE      = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VALUE = CSR_INDEX_W'(1);

   localparam logic [CHAN_W-1:0] MAX_VALUE_RESET = CHAN_W'(255);
   localparam logic [CHAN_W-1:0] CHAN_MAX        = CHAN_W'(255);

   typedef enum logic [1:0] {
      MODE_INVERT = 2'd0,
      MODE_GRAY   = 2'd1,
      MODE_SEPIA  = 2'd2,
      MODE_PASS   = 2'd3
   } mode_type;

   // Rounds a coefficient given in thousandths to the fixed-point format,
   // with halves rounded up.
   function automatic logic [COEF_W-1:0] coef(input longint thousandths);
      longint scaled;
      scaled = ((thousandths <<< COEF_FRAC_BITS) + 64'sd500) / 64'sd1000;
      return COEF_W'(scaled);
   endfunction

   // Coefficient matrix: one row per output channel, one column per input
   // channel (red, green, blue).
   typedef logic [0:2][0:2][COEF_W-1:0] coef_matrix_type;

   localparam coef_matrix_type GRAY_COEF = '{
      '{coef(299), coef(587), coef(114)},
      '{coef(299), coef(587), coef(114)},
      '{coef(299), coef(587), coef(114)}
   };

   localparam coef_matrix_type SEPIA_COEF = '{
      '{coef(393), coef(769), coef(189)},
      '{coef(349), coef(686), coef(168)},
      '{coef(272), coef(534), coef(131)}
   };

   // Channel payloads.
   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_payload_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
   } rsp_payload_type;

   // Pipeline stage payloads.
   typedef struct packed {
      mode_type                      mode;
      logic [0:2][CHAN_W-1:0]        bypass;
      logic [0:2][0:2][PROD_W-1:0]   prod;
   } mult_stage_type;

   typedef struct packed {
      mode_type                mode;
      logic [0:2][CHAN_W-1:0]  bypass;
      logic [0:2][SUM_W-1:0]   sum;
   } sum_stage_type;

endpackage

// ----- sv/pct_mult_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel color transform multiply stage
// Forms the nine channel-by-coefficient products and the invert or
// pass-through pixel, and registers them.
// ----------------------------------------------------------------------------
module pct_mult_stage
   import pct_pkg::*;
(
   input  logic             clock,
   input  logic             load,
   input  req_payload_type  pixel,
   input  mode_type         mode,
   input  logic [CHAN_W-1:0] max_value,
   output mult_stage_type   stage_q
);

   mult_stage_type          stage_ff;
   mult_stage_type          stage_in;
   coef_matrix_type         coef_sel;
   logic [0:2][CHAN_W-1:0]  chan;

   // Select the coefficient matrix for the current transform.
   always_comb begin
      case (mode)
         MODE_GRAY: begin
            coef_sel = GRAY_COEF;
         end
         default: begin
            coef_sel = SEPIA_COEF;
         end
      endcase
   end

   // Products and the bypass pixel for the transforms without arithmetic.
   always_comb begin
      chan[0] = pixel.red_in;
      chan[1] = pixel.green_in;
      chan[2] = pixel.blue_in;
      stage_in.mode = mode;
      for (int c = 0; c < 3; c++) begin
         if (mode == MODE_INVERT) begin
            stage_in.bypass[c] = max_value - chan[c];
         end else begin
            stage_in.bypass[c] = chan[c];
         end
      end
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            stage_in.prod[r][c] = PROD_W'(chan[c]) * PROD_W'(coef_sel[r][c]);
         end
      end
   end

   // Payload register, advanced when the pipeline moves.
   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_q = stage_ff;

endmodule

// ----- sv/pct_sum_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel color transform sum stage
// Adds the three products of each output channel exactly.
// ----------------------------------------------------------------------------
module pct_sum_stage
   import pct_pkg::*;
(
   input  logic            clock,
   input  logic            load,
   input  mult_stage_type  stage_d,
   output sum_stage_type   stage_q
);

   sum_stage_type  stage_ff;
   sum_stage_type  stage_in;

   // One three-term sum per output channel.
   always_comb begin
      stage_in.mode   = stage_d.mode;
      stage_in.bypass = stage_d.bypass;
      for (int r = 0; r < 3; r++) begin
         stage_in.sum[r] = SUM_W'(stage_d.prod[r][0]) + SUM_W'(stage_d.prod[r][1])
                         + SUM_W'(stage_d.prod[r][2]);
      end
   end

   // Payload register, advanced when the pipeline moves.
   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_q = stage_ff;

endmodule

// ----- sv/pct_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel color transform output stage
// Drops the fraction, saturates at full scale and selects the final pixel
// into the output register.
// ----------------------------------------------------------------------------
module pct_out_stage
   import pct_pkg::*;
(
   input  logic             clock,
   input  logic             load,
   input  sum_stage_type    stage_d,
   output rsp_payload_type  pixel
);

   rsp_payload_type         pixel_ff;
   rsp_payload_type         pixel_in;
   logic [0:2][INT_W-1:0]   whole;
   logic [0:2][CHAN_W-1:0]  sat;
   logic [0:2][CHAN_W-1:0]  result;

   // Truncate toward zero and clamp at the channel maximum.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         whole[r] = INT_W'(stage_d.sum[r] >> COEF_FRAC_BITS);
         if (whole[r] > INT_W'(CHAN_MAX)) begin
            sat[r] = CHAN_MAX;
         end else begin
            sat[r] = whole[r][CHAN_W-1:0];
         end
      end
   end

   // Weighted sums for grayscale and sepia, the bypass pixel otherwise.
   always_comb begin
      case (stage_d.mode)
         MODE_GRAY, MODE_SEPIA: begin
            result = sat;
         end
         default: begin
            result = stage_d.bypass;
         end
      endcase
      pixel_in.red_out   = result[0];
      pixel_in.green_out = result[1];
      pixel_in.blue_out  = result[2];
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel_in;
      end
   end

   assign pixel = pixel_ff;

endmodule

// ----- sv/pixel_color_transform.sv -----
`timescale 1ns / 1ps
// A request passes the multiply, sum and output registers in turn; rsp_valid
// rises once it reaches the output register, and holds there until taken.
// Throughput: one pixel per cycle while rsp_stall is low; the three register
// stages (multiply, sum, saturate and select) each take a new pixel every cycle.
// Reset: synchronous; empties the pipeline, mode returns to invert and
// max_value to 255.
// ----------------------------------------------------------------------------
// Pixel color transform
// Per-pixel invert, grayscale, sepia or pass-through of an RGB pixel with
// 8-bit channels, in a three-stage pipeline with valid/stall handshakes.
// ----------------------------------------------------------------------------
module pixel_color_transform
   import pct_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_payload_type         req_data,
   // Response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_payload_type         rsp_data,
   // Configuration port
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   mode_type           mode_ff;
   mode_type           mode_in;
   logic [CHAN_W-1:0]  max_value_ff;
   logic [CHAN_W-1:0]  max_value_in;

   logic               valid1_ff, valid1_in;
   logic               valid2_ff, valid2_in;
   logic               valid3_ff, valid3_in;
   logic               load1, load2, load3;

   mult_stage_type     mult_q;
   sum_stage_type      sum_q;

   // Configuration registers.
   always_comb begin
      mode_in      = mode_ff;
      max_value_in = max_value_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in = mode_type'(csr_wdata[1:0]);
            end
            CSR_MAX_VALUE: begin
               max_value_in = csr_wdata[CHAN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_INVERT;
         max_value_ff <= MAX_VALUE_RESET;
      end else begin
         mode_ff      <= mode_in;
         max_value_ff <= max_value_in;
      end
   end

   // A stage loads when it is empty or when the stage after it moves on.
   always_comb begin
      load3 = !valid3_ff || !rsp_stall;
      load2 = !valid2_ff || load3;
      load1 = !valid1_ff || load2;
      valid1_in = load1 ? req_valid : valid1_ff;
      valid2_in = load2 ? valid1_ff : valid2_ff;
      valid3_in = load3 ? valid2_ff : valid3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
      end
   end

   assign req_stall = !load1;
   assign rsp_valid = valid3_ff;

   // Datapath stages.
   pct_mult_stage u_mult (
      .clock     (clock),
      .load      (load1),
      .pixel     (req_data),
      .mode      (mode_ff),
      .max_value (max_value_ff),
      .stage_q   (mult_q)
   );

   pct_sum_stage u_sum (
      .clock   (clock),
      .load    (load2),
      .stage_d (mult_q),
      .stage_q (sum_q)
   );

   pct_out_stage u_out (
      .clock   (clock),
      .load    (load3),
      .stage_d (sum_q),
      .pixel   (rsp_data)
   );

endmodule
